// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HEAP_BYTES     = 4 * 1024 * 1024;
  localparam int unsigned HEADER_BYTES   = 32;
  localparam int unsigned ALIGN_BYTES    = 8;
  localparam int unsigned MAX_BLOCKS_DEF = 256;

  localparam int OFF_W     = 22;
  localparam int REQ_W     = 23;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 72;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REALLOC = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPTR = 2'd2;

  typedef logic [OFF_W-1:0] off_t;

  typedef struct packed {
    off_t start;
    off_t payload;
    logic free;
  } entry_t;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_A_START,
    OP_A_EV,
    OP_SH_WR,
    OP_A_SPLIT,
    OP_A_TAKE,
    OP_A_FAIL,
    OP_F_START,
    OP_F_EV,
    OP_BAD,
    OP_FOUND,
    OP_RF_EV,
    OP_FR_START,
    OP_FS_EV,
    OP_DN_WR,
    OP_DN_END,
    OP_FP_CHK,
    OP_FP_EV,
    OP_T_START,
    OP_T_EV,
    OP_T_END
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ptr_zero;
    logic              req_zero;
    logic              req_bad;
    logic              k_end;
    logic              fit;
    logic              split_ok;
    logic              match;
    logic              rmatch;
    logic              fits_old;
    logic              sh_more;
    logic              nxt_in;
    logic              tgt_nz;
    logic              rd_free;
    logic              out_busy;
  } sts_t;

endpackage

// ----- sv/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the allocator: walks the table scans, shifts and merges by
// issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [31:0] {
    S_INIT     = 32'h0000_0001,
    S_IDLE     = 32'h0000_0002,
    S_DISP     = 32'h0000_0004,
    S_A_START  = 32'h0000_0008,
    S_A_RD     = 32'h0000_0010,
    S_A_EV     = 32'h0000_0020,
    S_SH_CHK   = 32'h0000_0040,
    S_SH_WR    = 32'h0000_0080,
    S_A_SPLIT  = 32'h0000_0100,
    S_A_TAKE   = 32'h0000_0200,
    S_A_FAIL   = 32'h0000_0400,
    S_F_START  = 32'h0000_0800,
    S_F_RD     = 32'h0000_1000,
    S_F_EV     = 32'h0000_2000,
    S_BAD      = 32'h0000_4000,
    S_FOUND    = 32'h0000_8000,
    S_RF_START = 32'h0001_0000,
    S_RF_RD    = 32'h0002_0000,
    S_RF_EV    = 32'h0004_0000,
    S_FR_START = 32'h0008_0000,
    S_FS_RD    = 32'h0010_0000,
    S_FS_EV    = 32'h0020_0000,
    S_DN_CHK   = 32'h0040_0000,
    S_DN_WR    = 32'h0080_0000,
    S_DN_END   = 32'h0100_0000,
    S_FP_CHK   = 32'h0200_0000,
    S_FP_RD    = 32'h0400_0000,
    S_FP_EV    = 32'h0800_0000,
    S_T_START  = 32'h1000_0000,
    S_T_RD     = 32'h2000_0000,
    S_T_EV     = 32'h4000_0000,
    S_T_END    = 32'h8000_0000
  } state_t;

  state_t state, state_next;
  logic   pred, pred_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      pred  <= 1'b0;
    end else begin
      state <= state_next;
      pred  <= pred_next;
    end
  end

  always_comb begin
    state_next = state;
    pred_next  = pred;
    ctl.op     = OP_NOP;
    case (state)
      S_INIT: begin
        ctl.op     = OP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.func == FN_ALLOC) begin
          state_next = S_A_START;
        end else if (sts.func == FN_FREE) begin
          state_next = sts.ptr_zero ? S_T_START : S_F_START;
        end else if (sts.func == FN_REALLOC) begin
          state_next = sts.ptr_zero ? S_A_START : S_F_START;
        end else begin
          state_next = S_T_START;
        end
      end
      S_A_START: begin
        ctl.op     = OP_A_START;
        state_next = sts.req_bad ? S_A_FAIL : S_A_RD;
      end
      S_A_RD: begin
        state_next = sts.k_end ? S_A_FAIL : S_A_EV;
      end
      S_A_EV: begin
        ctl.op = OP_A_EV;
        if (sts.fit) begin
          state_next = sts.split_ok ? S_SH_CHK : S_A_TAKE;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_SH_CHK: begin
        state_next = sts.sh_more ? S_SH_WR : S_A_SPLIT;
      end
      S_SH_WR: begin
        ctl.op     = OP_SH_WR;
        state_next = S_SH_CHK;
      end
      S_A_SPLIT: begin
        ctl.op     = OP_A_SPLIT;
        state_next = S_A_TAKE;
      end
      S_A_TAKE: begin
        ctl.op = OP_A_TAKE;
        // a grown reallocation still has to release its old block
        if (sts.func == FN_REALLOC && !sts.ptr_zero) begin
          state_next = S_RF_START;
        end else begin
          state_next = S_T_START;
        end
      end
      S_A_FAIL: begin
        ctl.op     = OP_A_FAIL;
        state_next = S_T_START;
      end
      S_F_START: begin
        ctl.op     = OP_F_START;
        state_next = S_F_RD;
      end
      S_F_RD: begin
        state_next = sts.k_end ? S_BAD : S_F_EV;
      end
      S_F_EV: begin
        ctl.op     = OP_F_EV;
        state_next = sts.match ? S_FOUND : S_F_RD;
      end
      S_BAD: begin
        ctl.op     = OP_BAD;
        state_next = S_T_START;
      end
      S_FOUND: begin
        ctl.op = OP_FOUND;
        if (sts.func == FN_FREE || sts.req_zero) begin
          state_next = S_FR_START;
        end else if (sts.fits_old) begin
          state_next = S_T_START;
        end else begin
          state_next = S_A_START;
        end
      end
      S_RF_START: begin
        ctl.op     = OP_F_START;
        state_next = S_RF_RD;
      end
      S_RF_RD: begin
        state_next = sts.k_end ? S_T_START : S_RF_EV;
      end
      S_RF_EV: begin
        ctl.op     = OP_RF_EV;
        state_next = sts.rmatch ? S_FR_START : S_RF_RD;
      end
      S_FR_START: begin
        ctl.op     = OP_FR_START;
        pred_next  = 1'b0;
        state_next = sts.nxt_in ? S_FS_RD : S_FP_CHK;
      end
      S_FS_RD: begin
        state_next = S_FS_EV;
      end
      S_FS_EV: begin
        ctl.op     = OP_FS_EV;
        state_next = sts.rd_free ? S_DN_CHK : S_FP_CHK;
      end
      S_DN_CHK: begin
        state_next = sts.k_end ? S_DN_END : S_DN_WR;
      end
      S_DN_WR: begin
        ctl.op     = OP_DN_WR;
        state_next = S_DN_CHK;
      end
      S_DN_END: begin
        ctl.op     = OP_DN_END;
        state_next = pred ? S_T_START : S_FP_CHK;
      end
      S_FP_CHK: begin
        ctl.op     = OP_FP_CHK;
        state_next = sts.tgt_nz ? S_FP_RD : S_T_START;
      end
      S_FP_RD: begin
        state_next = S_FP_EV;
      end
      S_FP_EV: begin
        ctl.op = OP_FP_EV;
        if (sts.rd_free) begin
          pred_next  = 1'b1;
          state_next = S_DN_CHK;
        end else begin
          state_next = S_T_START;
        end
      end
      S_T_START: begin
        ctl.op     = OP_T_START;
        state_next = S_T_RD;
      end
      S_T_RD: begin
        state_next = sts.k_end ? S_T_END : S_T_EV;
      end
      S_T_EV: begin
        ctl.op     = OP_T_EV;
        state_next = S_T_RD;
      end
      S_T_END: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          ctl.op     = OP_T_END;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ----- sv/ffha_dp.sv -----
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath of the allocator: block table memory, scan index, working entry,
// totals and the result register.
// ----------------------------------------------------------------------------
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  logic [S_TDATA_W-1:0] s_tdata,
  output sts_t                 sts,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int WW = REQ_W + 3;
  localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);
  localparam logic [WW-1:0] HDR_W = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] ALN_W = WW'(ALIGN_BYTES);
  localparam logic [WW-1:0] AMSK  = WW'(ALIGN_BYTES - 1);
  localparam off_t          HDR   = OFF_W'(HEADER_BYTES);
  localparam off_t          INIT_PAYLOAD = OFF_W'(HEAP_BYTES - HEADER_BYTES);
  localparam int            PAD_W = M_TDATA_W - STAT_W - 3 * OFF_W;

  entry_t mem [MAX_BLOCKS];
  entry_t rdata;
  logic              we;
  logic [IW-1:0]     waddr;
  entry_t            wdata;

  logic [CW-1:0]     k, tgt, cnt;
  logic [FUNC_W-1:0] func_r;
  logic [REQ_W-1:0]  req_r;
  off_t              ptr_r;
  logic [WW-1:0]     sz;
  entry_t            cur;
  logic              split_r;
  off_t              oldstart;
  off_t              res_r;
  logic [STAT_W-1:0] stat_r;
  off_t              usum, fsum;

  logic [CW-1:0] k_inc, k_dec, tgt_inc;

  assign k_inc   = k + 1'b1;
  assign k_dec   = k - 1'b1;
  assign tgt_inc = tgt + 1'b1;

  always_comb begin
    sts.func     = func_r;
    sts.ptr_zero = (ptr_r == '0);
    sts.req_zero = (req_r == '0);
    sts.req_bad  = (req_r == '0) || (WW'(req_r) > WW'(HEAP_BYTES));
    sts.k_end    = (k >= cnt);
    sts.fit      = rdata.free && (WW'(rdata.payload) >= sz);
    sts.split_ok = (WW'(rdata.payload) >= sz + HDR_W + ALN_W) && (cnt < MAXC);
    sts.match    = !rdata.free && ((WW'(rdata.start) + HDR_W) == WW'(ptr_r));
    sts.rmatch   = (rdata.start == oldstart);
    sts.fits_old = (WW'(req_r) <= WW'(cur.payload));
    sts.sh_more  = (k > tgt);
    sts.nxt_in   = (tgt_inc < cnt);
    sts.tgt_nz   = (tgt != '0);
    sts.rd_free  = rdata.free;
    sts.out_busy = m_tvalid && !m_tready;
  end

  // Table write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (ctl.op)
      OP_INIT: begin
        we    = 1'b1;
        wdata = '{start: '0, payload: INIT_PAYLOAD, free: 1'b1};
      end
      OP_SH_WR: begin
        we    = 1'b1;
        waddr = k_inc[IW-1:0];
      end
      OP_A_SPLIT: begin
        we    = 1'b1;
        waddr = tgt_inc[IW-1:0];
        wdata = '{start:   OFF_W'(WW'(cur.start) + HDR_W + sz),
                  payload: OFF_W'(WW'(cur.payload) - sz - HDR_W),
                  free:    1'b1};
      end
      OP_A_TAKE: begin
        we    = 1'b1;
        waddr = tgt[IW-1:0];
        wdata = '{start: cur.start, payload: split_r ? OFF_W'(sz) : cur.payload,
                  free: 1'b0};
      end
      OP_DN_WR: begin
        we    = 1'b1;
        waddr = k_dec[IW-1:0];
      end
      OP_FP_CHK: begin
        we    = 1'b1;
        waddr = tgt[IW-1:0];
        wdata = cur;
      end
      OP_FP_EV: begin
        // absorb the freed block into its free predecessor
        we    = rdata.free;
        waddr = k[IW-1:0];
        wdata = '{start: rdata.start, payload: rdata.payload + HDR + cur.payload,
                  free: 1'b1};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= CW'(1);
      m_tvalid <= 1'b0;
    end else begin
      // a new result is only loaded once the previous one has gone
      if (ctl.op == OP_T_END) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (ctl.op)
        OP_A_SPLIT: cnt <= cnt + 1'b1;
        OP_DN_END:  cnt <= cnt - 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        func_r <= s_tdata[FUNC_W-1:0];
        req_r  <= s_tdata[FUNC_W +: REQ_W];
        ptr_r  <= s_tdata[FUNC_W + REQ_W +: OFF_W];
        sz     <= (WW'(s_tdata[FUNC_W +: REQ_W]) + AMSK) & ~AMSK;
        res_r  <= '0;
        stat_r <= ST_OK;
      end
      OP_A_START, OP_F_START: begin
        k <= '0;
      end
      OP_A_EV: begin
        if (sts.fit) begin
          cur     <= rdata;
          tgt     <= k;
          split_r <= sts.split_ok;
          k       <= cnt - 1'b1;
        end else begin
          k <= k_inc;
        end
      end
      OP_SH_WR: begin
        k <= k_dec;
      end
      OP_A_TAKE: begin
        res_r  <= OFF_W'(WW'(cur.start) + HDR_W);
        stat_r <= ST_OK;
      end
      OP_A_FAIL: begin
        res_r  <= '0;
        stat_r <= ST_FAIL;
      end
      OP_F_EV: begin
        if (sts.match) begin
          cur <= rdata;
          tgt <= k;
        end else begin
          k <= k_inc;
        end
      end
      OP_BAD: begin
        res_r  <= '0;
        stat_r <= ST_BADPTR;
      end
      OP_FOUND: begin
        oldstart <= cur.start;
        if (func_r == FN_REALLOC) begin
          if (req_r == '0) begin
            stat_r <= ST_FAIL;
          end else if (sts.fits_old) begin
            res_r <= ptr_r;
          end
        end
      end
      OP_RF_EV: begin
        if (sts.rmatch) begin
          cur <= rdata;
          tgt <= k;
        end else begin
          k <= k_inc;
        end
      end
      OP_FR_START: begin
        cur.free <= 1'b1;
        k        <= tgt_inc;
      end
      OP_FS_EV: begin
        if (rdata.free) begin
          cur.payload <= cur.payload + HDR + rdata.payload;
          k           <= tgt_inc + 1'b1;
        end
      end
      OP_DN_WR: begin
        k <= k_inc;
      end
      OP_FP_CHK: begin
        k <= tgt - 1'b1;
      end
      OP_FP_EV: begin
        if (rdata.free) begin
          k <= tgt_inc;
        end
      end
      OP_T_START: begin
        k    <= '0;
        usum <= '0;
        fsum <= '0;
      end
      OP_T_EV: begin
        if (rdata.free) begin
          fsum <= fsum + rdata.payload;
        end else begin
          usum <= usum + rdata.payload;
        end
        k <= k_inc;
      end
      OP_T_END: begin
        m_tdata <= {{PAD_W{1'b0}}, fsum, usum, stat_r, res_r};
      end
      default: begin
      end
    endcase
  end

  // Blocks tile the heap: payloads plus one header each cover it exactly
  assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_T_END) |->
      (32'(usum) + 32'(fsum) + 32'(cnt) * HEADER_BYTES == HEAP_BYTES))
    else $error("block table no longer covers the heap");

  assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && (32'(cnt) <= MAX_BLOCKS))
    else $error("block count out of range");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_A_SPLIT) |-> (cnt < MAXC) && split_r)
    else $error("split with a full table");

endmodule

// ----- sv/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator over an address-ordered block table.
//
//   Channel  Dir  Payload (low bit up)
//   s_*      in   func[1:0], req_size[24:2], ptr_offset[46:25], pad
//   m_*      out  result_offset[21:0], status[23:22], used_bytes[45:24],
//                 free_bytes[67:46], pad
//
// One transaction at a time; each table entry visited takes a read state
// and an evaluate state through the single registered read port of the
// table memory.
// After reset S_INIT writes the initial free block before s_tready rises.
// A new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // func, req_size, ptr_offset
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // result_offset, status, used, free
);

  ctl_t ctl;
  sts_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ffha_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .s_tdata  (s_tdata),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- tb/tb_first_fit_heap_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Self-checking bench for the first-fit heap allocator: a behavioural block
// table predicts every result, random stalls on both streams, heap exhaustion,
// a full block table and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;
  import ffha_pkg::*;

  localparam int          NBLK       = MAX_BLOCKS_DEF;
  localparam int unsigned HEAP_PAY   = HEAP_BYTES - HEADER_BYTES;
  localparam longint      CYCLE_CAP  = 40_000_000;
  localparam int          HOLD_CYC   = 3000;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    off_t              offset;
    logic [STAT_W-1:0] status;
    off_t              used;
    off_t              free;
  } heap_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  first_fit_heap_allocator_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block table
  int unsigned blk_start[NBLK];
  int unsigned blk_pay[NBLK];
  bit          blk_free[NBLK];
  int unsigned blk_cnt;

  heap_res_t pending_results[$];
  int        fail_count = 0;
  longint    cycle_count = 0;
  bit        quiet = 1'b0;     // no idling on either side
  bit        hold_req = 1'b0;  // ask the receiver for a long hold-off

  function automatic void table_reset();
    blk_start[0] = 0;
    blk_pay[0]   = HEAP_PAY;
    blk_free[0]  = 1'b1;
    blk_cnt      = 1;
  endfunction

  function automatic void drop_blk(int unsigned idx);
    for (int unsigned k = idx; k + 1 < blk_cnt; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_pay[k]   = blk_pay[k+1];
      blk_free[k]  = blk_free[k+1];
    end
    blk_cnt--;
  endfunction

  function automatic int unsigned find_used(int unsigned off);
    for (int unsigned k = 0; k < blk_cnt; k++)
      if (!blk_free[k] && blk_start[k] + HEADER_BYTES == off) return k;
    return blk_cnt;
  endfunction

  function automatic int unsigned grant_blk(int unsigned req);
    int unsigned sz;
    if (req == 0 || req > HEAP_BYTES) return 0;
    sz = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (!blk_free[i] || blk_pay[i] < sz) continue;
      if (blk_pay[i] >= sz + HEADER_BYTES + ALIGN_BYTES && blk_cnt < NBLK) begin
        for (int unsigned k = blk_cnt; k > i + 1; k--) begin
          blk_start[k] = blk_start[k-1];
          blk_pay[k]   = blk_pay[k-1];
          blk_free[k]  = blk_free[k-1];
        end
        blk_start[i+1] = blk_start[i] + HEADER_BYTES + sz;
        blk_pay[i+1]   = blk_pay[i] - sz - HEADER_BYTES;
        blk_free[i+1]  = 1'b1;
        blk_pay[i]     = sz;
        blk_cnt++;
      end
      blk_free[i] = 1'b0;
      return blk_start[i] + HEADER_BYTES;
    end
    return 0;
  endfunction

  // Merge with the successor first, then the predecessor
  function automatic void release_blk(int unsigned idx);
    blk_free[idx] = 1'b1;
    if (idx + 1 < blk_cnt && blk_free[idx+1]) begin
      blk_pay[idx] += HEADER_BYTES + blk_pay[idx+1];
      drop_blk(idx + 1);
    end
    if (idx > 0 && blk_free[idx-1]) begin
      blk_pay[idx-1] += HEADER_BYTES + blk_pay[idx];
      drop_blk(idx);
    end
  endfunction

  function automatic heap_res_t heap_step(logic [FUNC_W-1:0] fn, int unsigned req,
                                          int unsigned ptr);
    heap_res_t   r;
    int unsigned res = 0, idx, old_start, u = 0, f = 0;
    logic [STAT_W-1:0] st = ST_OK;
    case (fn)
      FN_ALLOC: begin
        res = grant_blk(req);
        st  = res ? ST_OK : ST_FAIL;
      end
      FN_FREE: begin
        if (ptr != 0) begin
          idx = find_used(ptr);
          if (idx < blk_cnt) release_blk(idx);
          else st = ST_BADPTR;
        end
      end
      FN_REALLOC: begin
        if (ptr == 0) begin
          res = grant_blk(req);
          st  = res ? ST_OK : ST_FAIL;
        end else begin
          idx = find_used(ptr);
          if (idx >= blk_cnt) st = ST_BADPTR;
          else if (req == 0) begin
            release_blk(idx);
            st = ST_FAIL;
          end else if (blk_pay[idx] >= req) res = ptr;
          else begin
            old_start = blk_start[idx];
            res = grant_blk(req);
            if (res) begin
              // a split may have moved the old entry up by one
              for (int unsigned k = 0; k < blk_cnt; k++)
                if (blk_start[k] == old_start) begin
                  release_blk(k);
                  break;
                end
            end else st = ST_FAIL;
          end
        end
      end
      default: ;
    endcase
    for (int unsigned k = 0; k < blk_cnt; k++)
      if (blk_free[k]) f += blk_pay[k];
      else u += blk_pay[k];
    r.offset = res[OFF_W-1:0];
    r.status = st;
    r.used   = u[OFF_W-1:0];
    r.free   = f[OFF_W-1:0];
    return r;
  endfunction

  // Payload offset of a random allocated block, or 0 when none
  function automatic int unsigned pick_live();
    int unsigned live[$];
    for (int unsigned k = 0; k < blk_cnt; k++)
      if (!blk_free[k]) live.push_back(blk_start[k] + HEADER_BYTES);
    if (live.size() == 0) return 0;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
      19:      return $urandom_range(60, 10);
      default: return $urandom_range(3, 1);
    endcase
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] fn, int unsigned req, int unsigned ptr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = '0;
    s_tdata[1:0]   = fn;
    s_tdata[24:2]  = req[REQ_W-1:0];
    s_tdata[46:25] = ptr[OFF_W-1:0];
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(heap_step(fn, req, ptr));
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus a counted hold-off on request
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    heap_res_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[21:0], m_tdata[23:22], m_tdata[45:24], m_tdata[67:46]};
      if (pending_results.size() == 0) begin
        $error("result with no pending request: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.offset !== want.offset) begin
          $error("result_offset: expected %0d, got %0d", want.offset, got.offset);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.used !== want.used) begin
          $error("used_bytes: expected %0d, got %0d", want.used, got.used);
          fail_count++;
        end
        if (got.free !== want.free) begin
          $error("free_bytes: expected %0d, got %0d", want.free, got.free);
          fail_count++;
        end
      end
    end
    if (cycle_count > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_corner_cases();
    int unsigned p, q;
    quiet = 1'b1;
    send_item(FN_ALLOC, 0, 0);                 // zero size
    send_item(FN_ALLOC, HEAP_BYTES + 1, 0);    // oversized
    send_item(FN_ALLOC, 23'h7FFFFF, 0);
    send_item(FN_ALLOC, HEAP_BYTES, 0);        // rounds above the whole payload
    send_item(FN_ALLOC, HEAP_PAY, 0);          // whole heap, no split
    send_item(FN_ALLOC, 8, 0);                 // heap exhausted
    send_item(FN_FREE, 0, HEADER_BYTES);
    send_item(FN_ALLOC, 1, 0);
    send_item(FN_ALLOC, 13, 0);
    send_item(FN_FREE, 0, 0);                  // null
    send_item(FN_FREE, 0, 22'h3FFFFF);         // bad pointer
    send_item(FN_REALLOC, 5, 22'h2AAAAA);      // bad pointer
    send_item(FN_REALLOC, 40, 0);              // null, acts as allocate
    p = pick_live();
    send_item(FN_REALLOC, 4, p);               // shrink, kept
    send_item(FN_REALLOC, 200, p);             // grow, moved
    send_item(FN_REALLOC, HEAP_BYTES, pick_live());  // cannot be met
    send_item(FN_REALLOC, 0, pick_live());     // zero size frees
    send_item(FN_UNUSED, 23'h555555, 22'h155555);
    q = pick_live();
    send_item(FN_FREE, 0, q);
    send_item(FN_FREE, 0, q);                  // double free
    p = pick_live();
    while (p != 0) begin
      send_item(FN_FREE, 0, p);
      p = pick_live();
    end
    quiet = 1'b0;
  endtask

  task automatic random_mix(int n, int alloc_pct, int max_req);
    int unsigned r, ptr, req;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 100) quiet = 1'b1;
      if (i % 150 == 130) quiet = 1'b0;
      r   = $urandom_range(99);
      req = ($urandom_range(49) == 0) ? $urandom() & 23'h7FFFFF : $urandom_range(max_req);
      ptr = pick_live();
      if ($urandom_range(19) == 0) ptr = $urandom() & 22'h3FFFFF;  // mostly bad
      if (r < alloc_pct) send_item(FN_ALLOC, req, 0);
      else if (r < alloc_pct + (100 - alloc_pct) / 2) send_item(FN_FREE, 0, ptr);
      else if (r < 98) send_item(FN_REALLOC, req, ptr);
      else send_item(FN_UNUSED, req, ptr);
    end
    quiet = 1'b0;
  endtask

  // Drive the table to its limit so allocations are granted unsplit
  task automatic test_table_full();
    random_mix(320, 85, 64);
    random_mix(80, 30, 512);
  endtask

  task automatic test_output_hold_off();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_item(FN_ALLOC, $urandom_range(100, 1), 0);
  endtask

  task automatic test_random_traffic();
    random_mix(350, 50, 256);
    random_mix(150, 55, 600000);
    random_mix(150, 45, 2000);
  endtask

  initial begin
    table_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_cases();
    test_table_full();
    test_output_hold_off();
    test_random_traffic();
    s_tvalid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- first_fit_heap_allocator_top.f -----
sv/ffha_pkg.sv
sv/ffha_ctrl.sv
sv/ffha_dp.sv
sv/first_fit_heap_allocator_top.sv
tb/tb_first_fit_heap_allocator_top.sv
